// ===== hw/rtl/c_source_bracket_checker_macros.svh =====
// Assertion macros for the bracket checker.
`ifndef C_SOURCE_BRACKET_CHECKER_MACROS_SVH
`define C_SOURCE_BRACKET_CHECKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cbc_pkg.sv =====
package cbc_pkg;

  // Stack geometry
  localparam int NESTING_DEPTH = 16;
  localparam int DEPTH_W       = $clog2(NESTING_DEPTH);
  localparam int LIM_W         = $clog2(NESTING_DEPTH + 1);

  // Result kinds
  localparam logic [2:0] KIND_STRAY_PAREN   = 3'd0;
  localparam logic [2:0] KIND_STRAY_BRACKET = 3'd1;
  localparam logic [2:0] KIND_OPEN_PAREN    = 3'd2;
  localparam logic [2:0] KIND_OPEN_BRACKET  = 3'd3;
  localparam logic [2:0] KIND_SUMMARY       = 3'd4;

  // Characters of interest
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_QUOTE     = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_PAREN   = 4'b0010,
    S_BRACKET = 4'b0100,
    S_SUMMARY = 4'b1000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic               step;
    logic               emit_paren;
    logic               emit_bracket;
    logic               emit_summary;
    logic [DEPTH_W-1:0] idx;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             slot_free;
    logic [LIM_W-1:0] paren_lim;
    logic [LIM_W-1:0] bracket_lim;
  } status_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

// ===== hw/rtl/c_source_bracket_checker.sv =====
// Channel  | Handshake                  | Payload
// input    | byte_valid / byte_ready     | text_byte, end_of_text
// result   | report_valid / report_ready | report_kind, line_number, column_number,
//          |                             | error_total, last_of_run
//
// Text bytes stream at one per cycle while the result register is free or being
// drained. An end-of-text transfer walks both open stacks through the shared
// result register: one report per recorded open (up to 16 per stack), then a summary.
// Reset (rst, synchronous) clears scanner state; stack entries are not cleared.
// A stalled result blocks new input until it is taken.
module c_source_bracket_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        report_valid,
  input  logic        report_ready,
  output logic [2:0]  report_kind,
  output logic [15:0] line_number,
  output logic [15:0] column_number,
  output logic [15:0] error_total,
  output logic        last_of_run
);

  cbc_pkg::cmd_t    cmd;
  cbc_pkg::status_t status;

  cbc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .end_of_text (end_of_text),
    .status      (status),
    .cmd         (cmd)
  );

  cbc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .text_byte     (text_byte),
    .report_valid  (report_valid),
    .report_ready  (report_ready),
    .report_kind   (report_kind),
    .line_number   (line_number),
    .column_number (column_number),
    .error_total   (error_total),
    .last_of_run   (last_of_run)
  );

endmodule

// ===== hw/rtl/cbc_datapath.sv =====
module cbc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  cbc_pkg::cmd_t       cmd,
  output cbc_pkg::status_t    status,
  input  logic [7:0]          text_byte,
  output logic                report_valid,
  input  logic                report_ready,
  output logic [2:0]          report_kind,
  output logic [15:0]         line_number,
  output logic [15:0]         column_number,
  output logic [15:0]         error_total,
  output logic                last_of_run
);

  logic [7:0]  previous_byte;
  logic        in_block_comment;
  logic        in_line_comment;
  logic        in_string;
  logic        in_char_constant;
  logic [15:0] paren_depth;
  logic [15:0] bracket_depth;
  logic [15:0] current_line_no;
  logic [15:0] current_column_no;
  logic [15:0] error_count;

  logic [31:0] paren_stack [cbc_pkg::NESTING_DEPTH];
  logic [31:0] bracket_stack [cbc_pkg::NESTING_DEPTH];

  logic        block_next;
  logic        line_next;
  logic        string_next;
  logic        char_next;
  logic        code_text;
  logic        push_paren;
  logic        pop_paren;
  logic        push_bracket;
  logic        pop_bracket;
  logic        paren_room;
  logic        bracket_room;
  logic [15:0] error_inc;
  logic [31:0] paren_entry;
  logic [31:0] bracket_entry;

  // Region tracking from the current and previous byte
  always_comb begin
    block_next = in_block_comment;
    if (!in_char_constant && !in_string && !in_line_comment) begin
      if (text_byte == cbc_pkg::CH_STAR && previous_byte == cbc_pkg::CH_SLASH) begin
        block_next = 1'b1;
      end else if (text_byte == cbc_pkg::CH_SLASH && previous_byte == cbc_pkg::CH_STAR) begin
        block_next = 1'b0;
      end
    end
    line_next = in_line_comment;
    if (!in_char_constant && !in_string && !block_next) begin
      if (text_byte == cbc_pkg::CH_SLASH && previous_byte == cbc_pkg::CH_SLASH) begin
        line_next = 1'b1;
      end else if (text_byte == cbc_pkg::CH_NEWLINE) begin
        line_next = 1'b0;
      end
    end
    string_next = in_string;
    if (!line_next && !block_next && !in_char_constant &&
        text_byte == cbc_pkg::CH_DQUOTE && previous_byte != cbc_pkg::CH_BACKSLASH) begin
      string_next = !in_string;
    end
    char_next = in_char_constant;
    if (!line_next && !block_next && !string_next && text_byte == cbc_pkg::CH_QUOTE) begin
      char_next = !in_char_constant;
    end
    code_text = !line_next && !block_next && !string_next && !char_next;
  end

  // Bracket events
  assign push_paren   = code_text && (text_byte == cbc_pkg::CH_LPAREN);
  assign pop_paren    = code_text && (text_byte == cbc_pkg::CH_RPAREN);
  assign push_bracket = code_text && (text_byte == cbc_pkg::CH_LBRACKET);
  assign pop_bracket  = code_text && (text_byte == cbc_pkg::CH_RBRACKET);
  assign paren_room   = paren_depth < 16'(cbc_pkg::NESTING_DEPTH);
  assign bracket_room = bracket_depth < 16'(cbc_pkg::NESTING_DEPTH);
  assign error_inc    = cbc_pkg::sat_inc16(error_count);

  // Status: walk limits and output slot
  assign status.slot_free   = !report_valid || report_ready;
  assign status.paren_lim   = paren_room ? paren_depth[cbc_pkg::LIM_W-1:0]
                                         : cbc_pkg::LIM_W'(cbc_pkg::NESTING_DEPTH);
  assign status.bracket_lim = bracket_room ? bracket_depth[cbc_pkg::LIM_W-1:0]
                                           : cbc_pkg::LIM_W'(cbc_pkg::NESTING_DEPTH);

  assign paren_entry   = paren_stack[cmd.idx];
  assign bracket_entry = bracket_stack[cmd.idx];

  // Open-position stacks
  always_ff @(posedge clk) begin
    if (cmd.step && push_paren && paren_room) begin
      paren_stack[paren_depth[cbc_pkg::DEPTH_W-1:0]] <= {current_line_no, current_column_no};
    end
    if (cmd.step && push_bracket && bracket_room) begin
      bracket_stack[bracket_depth[cbc_pkg::DEPTH_W-1:0]] <=
        {current_line_no, current_column_no};
    end
  end

  // Scanner state and error counter
  always_ff @(posedge clk) begin
    if (rst || cmd.emit_summary) begin
      previous_byte     <= '0;
      in_block_comment  <= 1'b0;
      in_line_comment   <= 1'b0;
      in_string         <= 1'b0;
      in_char_constant  <= 1'b0;
      paren_depth       <= '0;
      bracket_depth     <= '0;
      current_line_no   <= 16'd1;
      current_column_no <= 16'd1;
      error_count       <= '0;
    end else if (cmd.step) begin
      previous_byte    <= text_byte;
      in_block_comment <= block_next;
      in_line_comment  <= line_next;
      in_string        <= string_next;
      in_char_constant <= char_next;
      if (push_paren) begin
        paren_depth <= cbc_pkg::sat_inc16(paren_depth);
      end else if (pop_paren && paren_depth != 16'd0) begin
        paren_depth <= paren_depth - 16'd1;
      end
      if (push_bracket) begin
        bracket_depth <= cbc_pkg::sat_inc16(bracket_depth);
      end else if (pop_bracket && bracket_depth != 16'd0) begin
        bracket_depth <= bracket_depth - 16'd1;
      end
      if ((pop_paren && paren_depth == 16'd0) || (pop_bracket && bracket_depth == 16'd0)) begin
        error_count <= error_inc;
      end
      if (text_byte == cbc_pkg::CH_NEWLINE) begin
        current_line_no   <= cbc_pkg::sat_inc16(current_line_no);
        current_column_no <= 16'd1;
      end else begin
        current_column_no <= cbc_pkg::sat_inc16(current_column_no);
      end
    end else if (cmd.emit_paren || cmd.emit_bracket) begin
      error_count <= error_inc;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if ((cmd.step && ((pop_paren && paren_depth == 16'd0) ||
                               (pop_bracket && bracket_depth == 16'd0))) ||
                 cmd.emit_paren || cmd.emit_bracket || cmd.emit_summary) begin
      report_valid <= 1'b1;
    end else if (report_ready) begin
      report_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      report_kind   <= (pop_paren) ? cbc_pkg::KIND_STRAY_PAREN : cbc_pkg::KIND_STRAY_BRACKET;
      line_number   <= current_line_no;
      column_number <= current_column_no;
      error_total   <= error_inc;
      last_of_run   <= 1'b1;
    end else if (cmd.emit_paren) begin
      report_kind   <= cbc_pkg::KIND_OPEN_PAREN;
      line_number   <= paren_entry[31:16];
      column_number <= paren_entry[15:0];
      error_total   <= error_inc;
      last_of_run   <= 1'b0;
    end else if (cmd.emit_bracket) begin
      report_kind   <= cbc_pkg::KIND_OPEN_BRACKET;
      line_number   <= bracket_entry[31:16];
      column_number <= bracket_entry[15:0];
      error_total   <= error_inc;
      last_of_run   <= 1'b0;
    end else if (cmd.emit_summary) begin
      report_kind   <= cbc_pkg::KIND_SUMMARY;
      line_number   <= '0;
      column_number <= '0;
      error_total   <= error_count;
      last_of_run   <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/cbc_ctrl.sv =====
module cbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  logic              end_of_text,
  input  cbc_pkg::status_t  status,
  output cbc_pkg::cmd_t     cmd
);

  cbc_pkg::state_t           state;
  cbc_pkg::state_t           state_next;
  logic [cbc_pkg::LIM_W-1:0] idx;
  logic [cbc_pkg::LIM_W-1:0] idx_next;
  logic                      in_fire;

  assign byte_ready = (state == cbc_pkg::S_IDLE) && status.slot_free;
  assign in_fire    = byte_valid && byte_ready;

  // Sequencer: byte scan, then paren walk, bracket walk, summary
  always_comb begin
    state_next       = state;
    idx_next         = idx;
    cmd.step         = 1'b0;
    cmd.emit_paren   = 1'b0;
    cmd.emit_bracket = 1'b0;
    cmd.emit_summary = 1'b0;
    cmd.idx          = idx[cbc_pkg::DEPTH_W-1:0];
    case (state)
      cbc_pkg::S_IDLE: begin
        if (in_fire) begin
          if (end_of_text) begin
            state_next = cbc_pkg::S_PAREN;
            idx_next   = '0;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      cbc_pkg::S_PAREN: begin
        if (idx == status.paren_lim) begin
          state_next = cbc_pkg::S_BRACKET;
          idx_next   = '0;
        end else if (status.slot_free) begin
          cmd.emit_paren = 1'b1;
          idx_next       = idx + 1'b1;
        end
      end
      cbc_pkg::S_BRACKET: begin
        if (idx == status.bracket_lim) begin
          state_next = cbc_pkg::S_SUMMARY;
          idx_next   = '0;
        end else if (status.slot_free) begin
          cmd.emit_bracket = 1'b1;
          idx_next         = idx + 1'b1;
        end
      end
      cbc_pkg::S_SUMMARY: begin
        if (status.slot_free) begin
          cmd.emit_summary = 1'b1;
          state_next       = cbc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cbc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbc_pkg::S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// ===== hw/rtl/cbc_checker.sv =====
`include "c_source_bracket_checker_macros.svh"

module cbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_valid,
  input logic        byte_ready,
  input logic        end_of_text,
  input logic        report_valid,
  input logic        report_ready,
  input logic [2:0]  report_kind,
  input logic [15:0] line_number,
  input logic [15:0] column_number,
  input logic [15:0] error_total,
  input logic        last_of_run
);

  logic        byte_fire;
  logic        byte_step;
  logic        result_stall;
  logic        summary_kind;
  logic        open_kind;
  logic        stray_kind;
  logic [31:0] position;
  logic [51:0] payload;

  // Handshake and result decode
  assign byte_fire    = byte_valid && byte_ready;
  assign byte_step    = byte_fire && !end_of_text;
  assign result_stall = report_valid && !report_ready;
  assign summary_kind = report_valid && (report_kind == cbc_pkg::KIND_SUMMARY);
  assign open_kind    = (report_kind == cbc_pkg::KIND_OPEN_PAREN) ||
                        (report_kind == cbc_pkg::KIND_OPEN_BRACKET);
  assign stray_kind   = (report_kind == cbc_pkg::KIND_STRAY_PAREN) ||
                        (report_kind == cbc_pkg::KIND_STRAY_BRACKET);
  assign position     = {line_number, column_number};
  assign payload      = {report_kind, line_number, column_number, error_total, last_of_run};

  // A stalled result holds
  `CBC_ASSERT_NEXT(a_hold, result_stall, report_valid && $stable(payload), "held result changed")
  // Summary closes the run and carries no position
  `CBC_ASSERT_SAME(a_summary, summary_kind, last_of_run && position == 32'd0, "bad summary")
  // Open reports never end a run
  `CBC_ASSERT_SAME(a_open_not_last, report_valid && open_kind, !last_of_run, "open marked last")
  // End of text stops input for the report walk
  `CBC_ASSERT_NEXT(a_eot_blocks, byte_fire && end_of_text, !byte_ready, "input taken in walk")
  // Byte results are stray closes only
  `CBC_ASSERT_NEXT(a_byte_result, byte_step, !report_valid || stray_kind, "bad byte result")

endmodule

bind c_source_bracket_checker cbc_checker u_cbc_checker (.*);
